@@ hdl/dccpb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpb_pkg: shared types and constants of the DCC speed/direction builder
// Holds the token that walks the decoder chain and the packet field widths.
// ----------------------------------------------------------------------------
package dccpb_pkg;

  localparam int ADDR_W  = 8;
  localparam int VALUE_W = 8;
  localparam int SPEED_W = 5;

  // Operation codes carried in the command.
  localparam logic OP_SPEED     = 1'b0;
  localparam logic OP_DIRECTION = 1'b1;

  // Fixed fields of the baseline instruction byte 01DCSSSS.
  localparam logic [1:0] INSTR_PREFIX = 2'b01;

  // Defaults of a newly allocated decoder entry.
  localparam logic [SPEED_W-1:0] SPEED_INIT = '0;
  localparam logic               DIR_INIT   = 1'b1;

  // One command on its way through the chain of decoder cells.
  typedef struct packed {
    logic               busy;   // token present in this stage
    logic               op;     // OP_SPEED or OP_DIRECTION
    logic [ADDR_W-1:0]  addr;   // decoder address
    logic [SPEED_W-1:0] value;  // new speed, or direction in bit 0
    logic               hit;    // some cell already served the command
    logic [SPEED_W-1:0] speed;  // speed after the update, once hit
    logic               dir;    // direction after the update, once hit
  } token_t;

endpackage

@@ hdl/dcc_speed_direction_packet_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_speed_direction_packet_builder: DCC baseline speed/direction packets
// Keeps a table of decoders and turns each command into a three-byte packet or a table-full beat.
// ----------------------------------------------------------------------------
// A user sends one command beat (set speed or set direction of a decoder
// address) and receives either the three bytes of a baseline packet, the
// address, the instruction byte 01DCSSSS and the XOR check, with tlast on the
// check byte, or a single beat with tuser high and tlast high when the
// address is new and all MAX_DECODERS entries are taken. The table is a row
// of cells, one per decoder; a command walks the row one cell per cycle, and
// the block then presents its result beats. One command is handled at a time:
// no new command is taken until the last result beat of the previous one has
// been accepted. Reset empties the table at once.
// ----------------------------------------------------------------------------
module dcc_speed_direction_packet_builder #(
  parameter int MAX_DECODERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] operation, [8:1] address, [16:9] value, [23:17] zero
  // Packet byte stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] packet_byte
  output logic        m_tlast,
  output logic        m_tuser    // [0] status: 1 means table full, no packet
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    BEAT_ADDR,
    BEAT_INSTR,
    BEAT_CHECK
  } beat_t;

  state_t state;
  beat_t  beat;

  // tok[0] enters the first cell; tok[i+1] leaves cell i.
  dccpb_pkg::token_t tok [MAX_DECODERS+1];
  logic [MAX_DECODERS-1:0] busy_vec;

  logic                          s_accept;
  logic                          m_accept;
  logic                          full;
  logic [dccpb_pkg::ADDR_W-1:0]  byte_addr;
  logic [7:0]                    byte_instr;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_SEND);
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // A command enters the chain only on the accepting edge.
  always_comb begin
    tok[0].busy  = s_accept;
    tok[0].op    = s_tdata[0];
    tok[0].addr  = s_tdata[8:1];
    tok[0].value = s_tdata[9 +: dccpb_pkg::SPEED_W];
    tok[0].hit   = 1'b0;
    tok[0].speed = '0;
    tok[0].dir   = 1'b0;
  end

  for (genvar i = 0; i < MAX_DECODERS; i++) begin : g_cell
    dccpb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign busy_vec[i] = tok[i+1].busy;
  end

  // Sequencer: wait for the token to leave the last cell, then send beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      beat  <= BEAT_ADDR;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (tok[MAX_DECODERS].busy) begin
            state <= ST_SEND;
            beat  <= BEAT_ADDR;
          end
        end
        ST_SEND: begin
          if (m_accept) begin
            if (full || beat == BEAT_CHECK) begin
              state <= ST_IDLE;
            end else if (beat == BEAT_ADDR) begin
              beat <= BEAT_INSTR;
            end else begin
              beat <= BEAT_CHECK;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Packet bytes are captured once, when the token reaches the end of the row.
  always_ff @(posedge clk) begin
    if (state == ST_WALK && tok[MAX_DECODERS].busy) begin
      full       <= !tok[MAX_DECODERS].hit;
      byte_addr  <= tok[MAX_DECODERS].addr;
      byte_instr <= {dccpb_pkg::INSTR_PREFIX, tok[MAX_DECODERS].dir,
                     tok[MAX_DECODERS].speed[0],
                     tok[MAX_DECODERS].speed[dccpb_pkg::SPEED_W-1:1]};
    end
  end

  always_comb begin
    m_tdata = byte_addr;
    m_tlast = 1'b0;
    m_tuser = full;
    if (full) begin
      m_tdata = '0;
      m_tlast = 1'b1;
    end else begin
      unique case (beat)
        BEAT_ADDR:  m_tdata = byte_addr;
        BEAT_INSTR: m_tdata = byte_instr;
        BEAT_CHECK: begin
          m_tdata = byte_addr ^ byte_instr;
          m_tlast = 1'b1;
        end
        default:    m_tdata = byte_addr;
      endcase
    end
  end

  // Only one command is ever inside the cell row.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(busy_vec))
    else $error("more than one command in the decoder chain");

  // No new command is taken while one is still walking the row.
  a_idle_chain: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (busy_vec == '0))
    else $error("command accepted while the chain is busy");

  // A table-full beat is always the only and last beat of its command.
  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("table-full beat without tlast");

  // Results only follow a command that went the whole way down the row.
  a_send_after_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(tok[MAX_DECODERS].busy))
    else $error("result beats started without a finished walk");

endmodule

@@ hdl/dccpb_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpb_cell: one decoder entry of the chain
// Serves a passing command that matches its address or claims it when empty,
// then hands the token on to the next cell through its registered output.
// ----------------------------------------------------------------------------
module dccpb_cell (
  input  logic              clk,
  input  logic              rst,
  input  dccpb_pkg::token_t tok_in,
  output dccpb_pkg::token_t tok_out
);

  logic                                entry_valid;
  logic [dccpb_pkg::ADDR_W-1:0]        entry_address;
  logic [dccpb_pkg::SPEED_W-1:0]       entry_speed;
  logic                                entry_direction;

  logic                                take;
  logic [dccpb_pkg::SPEED_W-1:0]       speed_next;
  logic                                dir_next;

  // Entries fill from the bottom and are never freed, so an empty cell met
  // before any match means the address is new and this cell gets it.
  assign take = tok_in.busy && !tok_in.hit &&
                (!entry_valid || (entry_address == tok_in.addr));

  always_comb begin
    speed_next = entry_valid ? entry_speed : dccpb_pkg::SPEED_INIT;
    dir_next   = entry_valid ? entry_direction : dccpb_pkg::DIR_INIT;
    unique case (tok_in.op)
      dccpb_pkg::OP_SPEED:     speed_next = tok_in.value;
      dccpb_pkg::OP_DIRECTION: dir_next   = tok_in.value[0];
      default:                 speed_next = tok_in.value;
    endcase
  end

  // Only the valid bit and the token's busy flag need a reset; the rest is
  // qualified by them.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= 1'b0;
      tok_out.busy <= 1'b0;
    end else begin
      tok_out.busy <= tok_in.busy;
      if (take) begin
        entry_valid <= 1'b1;
      end
    end
    tok_out.op    <= tok_in.op;
    tok_out.addr  <= tok_in.addr;
    tok_out.value <= tok_in.value;
    if (take) begin
      entry_address   <= tok_in.addr;
      entry_speed     <= speed_next;
      entry_direction <= dir_next;
      tok_out.hit     <= 1'b1;
      tok_out.speed   <= speed_next;
      tok_out.dir     <= dir_next;
    end else begin
      tok_out.hit   <= tok_in.hit;
      tok_out.speed <= tok_in.speed;
      tok_out.dir   <= tok_in.dir;
    end
  end

endmodule

@@ tb/dccpb_packet_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccpb_packet_checker: scoreboard for the DCC speed/direction builder
// Watches the command and packet streams. It keeps its own decoder table,
// predicts the beats for every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module dccpb_packet_checker #(
  parameter int MAX_DECODERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] operation, [8:1] address, [16:9] value, [23:17] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] packet_byte
  input  logic        m_tlast,
  input  logic        m_tuser,   // [0] status
  output int          mismatch_count,
  output int          beats_outstanding
);

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last;
    logic       status;
  } packet_beat_t;

  // Model of the decoder table.
  logic                          dec_valid [MAX_DECODERS];
  logic [dccpb_pkg::ADDR_W-1:0]  dec_addr  [MAX_DECODERS];
  logic [dccpb_pkg::SPEED_W-1:0] dec_speed [MAX_DECODERS];
  logic                          dec_dir   [MAX_DECODERS];

  packet_beat_t packet_beats_q[$];

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] wanted);
    $display("%0t ns mismatch: %s got %0h wanted %0h", $time, what, got, wanted);
    mismatch_count++;
  endtask

  // Applies one command to the table and queues the beats it must produce.
  function automatic void build_packet(input logic op,
                                       input logic [dccpb_pkg::ADDR_W-1:0] addr,
                                       input logic [dccpb_pkg::VALUE_W-1:0] value);
    int                 slot;
    int                 free_slot;
    logic [7:0]         instr;
    packet_beat_t       beat;
    slot      = -1;
    free_slot = -1;
    for (int i = 0; i < MAX_DECODERS; i++) begin
      if (dec_valid[i]) begin
        if (slot < 0 && dec_addr[i] == addr) slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (slot < 0 && free_slot >= 0) begin
      slot               = free_slot;
      dec_valid[slot]    = 1'b1;
      dec_addr[slot]     = addr;
      dec_speed[slot]    = dccpb_pkg::SPEED_INIT;
      dec_dir[slot]      = dccpb_pkg::DIR_INIT;
    end
    if (slot < 0) begin
      // Unknown address and no room: one status beat, table untouched.
      beat = '{pkt_byte: 8'h00, last: 1'b1, status: 1'b1};
      packet_beats_q.push_back(beat);
      return;
    end
    if (op == dccpb_pkg::OP_SPEED) dec_speed[slot] = value[dccpb_pkg::SPEED_W-1:0];
    else dec_dir[slot] = value[0];
    instr = {dccpb_pkg::INSTR_PREFIX, dec_dir[slot], dec_speed[slot][0],
             dec_speed[slot][dccpb_pkg::SPEED_W-1:1]};
    beat = '{pkt_byte: dec_addr[slot], last: 1'b0, status: 1'b0};
    packet_beats_q.push_back(beat);
    beat = '{pkt_byte: instr, last: 1'b0, status: 1'b0};
    packet_beats_q.push_back(beat);
    beat = '{pkt_byte: dec_addr[slot] ^ instr, last: 1'b1, status: 1'b0};
    packet_beats_q.push_back(beat);
  endfunction

  always @(posedge clk) begin
    packet_beat_t wanted;
    if (rst) begin
      for (int i = 0; i < MAX_DECODERS; i++) dec_valid[i] = 1'b0;
      packet_beats_q.delete();
    end else begin
      // The output side is checked first: a beat leaving at the same edge as
      // a command arrives can only belong to an older command.
      if (m_tvalid && m_tready) begin
        if (packet_beats_q.size() == 0) begin
          report_mismatch("unexpected packet beat", m_tdata, 8'h00);
        end else begin
          wanted = packet_beats_q.pop_front();
          if (m_tdata !== wanted.pkt_byte)
            report_mismatch("packet_byte", m_tdata, wanted.pkt_byte);
          if (m_tlast !== wanted.last)
            report_mismatch("last", {7'd0, m_tlast}, {7'd0, wanted.last});
          if (m_tuser !== wanted.status)
            report_mismatch("status", {7'd0, m_tuser}, {7'd0, wanted.status});
        end
      end
      if (s_tvalid && s_tready)
        build_packet(s_tdata[0], s_tdata[8:1], s_tdata[16:9]);
    end
    beats_outstanding = packet_beats_q.size();
  end

endmodule

@@ tb/tb_dcc_speed_direction_packet_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dcc_speed_direction_packet_builder: testbench of the DCC packet builder
// Drives directed commands that fill the decoder table and overflow it, then
// random speed and direction commands, with bursty input and a stalling
// output. A scoreboard module predicts and checks every packet beat.
// ----------------------------------------------------------------------------
module tb_dcc_speed_direction_packet_builder;

  localparam int NUM_DECODERS  = 16;
  localparam int RANDOM_CMDS   = 186;
  // Settling time at the end: one walk through the cell row plus margin.
  localparam int DRAIN_CYCLES  = NUM_DECODERS + 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;      // [0] operation, [8:1] address, [16:9] value, [23:17] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] packet_byte
  logic        m_tlast;
  logic        m_tuser;           // [0] status
  int          mismatch_count;
  int          beats_outstanding;

  // Addresses that the directed part places in the table; the random part
  // mostly reuses them so that most commands hit a live decoder.
  logic [dccpb_pkg::ADDR_W-1:0] known_addr [NUM_DECODERS];
  int                           burst_left;

  // Receiver stall pattern: a mode is picked for a random stretch of cycles.
  int ready_mode;
  int mode_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dcc_speed_direction_packet_builder #(
    .MAX_DECODERS(NUM_DECODERS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  dccpb_packet_checker #(
    .MAX_DECODERS(NUM_DECODERS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .m_tuser          (m_tuser),
    .mismatch_count   (mismatch_count),
    .beats_outstanding(beats_outstanding)
  );

  // The output side is always ready, stalls at random, or toggles every
  // cycle. The modes change independently of the command stream, so stalls
  // land on the address, instruction and check beats alike.
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      ready_mode  <= 0;
      mode_cycles <= 0;
    end else begin
      if (mode_cycles == 0) begin
        ready_mode  <= $urandom_range(0, 2);
        mode_cycles <= $urandom_range(20, 80);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  // Presents one command beat and holds it until the block takes it. Valid
  // stays high into the next beat of a burst; at the end of a burst it drops
  // for a random gap. Occasionally a long burst gives a stretch with no gaps.
  task automatic issue_command(input logic op, input logic [dccpb_pkg::ADDR_W-1:0] addr,
                               input logic [dccpb_pkg::VALUE_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, value, addr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 40);
      else burst_left = $urandom_range(1, 8);
    end
  endtask

  initial begin
    logic                         op;
    logic [dccpb_pkg::ADDR_W-1:0] addr;
    known_addr = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                   8'h40, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h7E, 8'h81};
    burst_left = $urandom_range(1, 8);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Lowest and highest address. The upper value bits must be ignored:
    // speed takes only bits 4..0 and direction only bit 0.
    issue_command(dccpb_pkg::OP_SPEED,     8'h00, 8'hFF);
    issue_command(dccpb_pkg::OP_DIRECTION, 8'h00, 8'hFE);
    issue_command(dccpb_pkg::OP_SPEED,     8'hFF, 8'h00);
    issue_command(dccpb_pkg::OP_DIRECTION, 8'hFF, 8'h01);
    issue_command(dccpb_pkg::OP_SPEED,     8'hFF, 8'hE0);
    issue_command(dccpb_pkg::OP_SPEED,     8'h00, 8'h01);
    issue_command(dccpb_pkg::OP_SPEED,     8'h00, 8'h1E);

    // Fill the remaining entries, alternating speed and direction commands,
    // so a new entry shows its default speed or direction in the packet.
    for (int i = 2; i < NUM_DECODERS; i++) begin
      op = (i % 2 == 0) ? dccpb_pkg::OP_SPEED : dccpb_pkg::OP_DIRECTION;
      issue_command(op, known_addr[i], 8'((i * 37) ^ 8'h5A));
    end

    // The table is full now: new addresses get the status beat for both
    // operations, while a known address is still served.
    issue_command(dccpb_pkg::OP_SPEED,     8'h33, 8'h1F);
    issue_command(dccpb_pkg::OP_DIRECTION, 8'hCC, 8'h01);
    issue_command(dccpb_pkg::OP_SPEED,     8'hFF, 8'h0A);

    // Random commands: most target live decoders with random values, the
    // rest use random addresses, which mostly run into the full table.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) addr = known_addr[$urandom_range(0, NUM_DECODERS - 1)];
      else addr = 8'($urandom_range(0, 255));
      issue_command(op, addr, 8'($urandom_range(0, 255)));
    end
    s_tvalid <= 1'b0;

    // Sample the scoreboard away from the rising edge to avoid racing it.
    @(negedge clk);
    while (beats_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs and reports it as failed.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
